// ===== rtl/cse_pkg.sv =====
// Shared types, constants and character helpers for the C string literal escaper.
`default_nettype none
package cse_pkg;

    localparam int unsigned CAP_W       = 16;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned ESC_MAX_LEN = 5;
    localparam int unsigned IDX_W       = $clog2(ESC_MAX_LEN);
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        PH_HELD,
        PH_FLUSH,
        PH_TERM
    } phase_t;

    typedef struct packed {
        logic [IDX_W-1:0]  len;
        logic [CHAR_W-1:0] ch;
        logic              is_hex;
    } esc_info_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              str_end;
    } out_word_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    // Letter of a simple escape; hit is low for bytes with no such escape.
    function automatic logic [CHAR_W:0] esc_letter(input logic [CHAR_W-1:0] b);
        logic [CHAR_W:0] r;
        case (b)
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3F:   r = {1'b1, 8'h3F};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h07:   r = {1'b1, 8'h61};
            8'h08:   r = {1'b1, 8'h62};
            8'h0C:   r = {1'b1, 8'h66};
            8'h0A:   r = {1'b1, 8'h6E};
            8'h0D:   r = {1'b1, 8'h72};
            8'h09:   r = {1'b1, 8'h74};
            8'h0B:   r = {1'b1, 8'h76};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cse_escape.sv =====
// Escape decoder: length, hex flag and the character at one position of a byte's escape.
`default_nettype none
module cse_escape (
    input  wire logic [cse_pkg::CHAR_W-1:0] byte_in,
    input  wire logic                       prev_hex,
    input  wire logic                       next_is_digit,
    input  wire logic [cse_pkg::IDX_W-1:0]  idx,
    output cse_pkg::esc_info_t              info
);

    logic [cse_pkg::CHAR_W:0] letter;
    logic                     printable;
    logic                     xdigit;

    always_comb begin
        letter    = cse_pkg::esc_letter(byte_in);
        printable = byte_in inside {[8'h20:8'h7E]};
        xdigit    = byte_in inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        info      = '0;
        if (byte_in == 8'h00) begin
            // A zero before a decimal digit needs the full octal form.
            info.len = next_is_digit ? 3'd4 : 3'd2;
            info.ch  = (idx == '0) ? cse_pkg::CH_BSLASH : cse_pkg::CH_ZERO;
        end else if (letter[cse_pkg::CHAR_W]) begin
            info.len = 3'd2;
            info.ch  = (idx == '0) ? cse_pkg::CH_BSLASH : letter[cse_pkg::CHAR_W-1:0];
        end else if (printable && !(prev_hex && xdigit)) begin
            info.len = 3'd1;
            info.ch  = byte_in;
        end else begin
            info.len    = 3'd5;
            info.is_hex = 1'b1;
            case (idx)
                3'd0:    info.ch = cse_pkg::CH_BSLASH;
                3'd1:    info.ch = cse_pkg::CH_X;
                3'd2:    info.ch = cse_pkg::CH_ZERO;
                3'd3:    info.ch = cse_pkg::hex_char(byte_in[7:4]);
                default: info.ch = cse_pkg::hex_char(byte_in[3:0]);
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cse_out_reg.sv =====
// Output register of the result channel.
`default_nettype none
module cse_out_reg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire cse_pkg::out_word_t         word_in,
    output logic                            out_free,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [cse_pkg::CHAR_W-1:0]      m_tdata,
    output logic                            m_tlast
);

    logic               valid_reg;
    cse_pkg::out_word_t word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_in;
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg.ch;
    assign m_tlast  = word_reg.str_end;

endmodule
`default_nettype wire

// ===== rtl/c_string_literal_escaper.sv =====
// Top level of the C string literal escaper: word sequencer, state and configuration.
//
//  channel  | valid/ready       | payload
//  ---------+-------------------+------------------------------------------------
//  input    | s_tvalid/s_tready | s_tdata=data_byte, s_tuser=has_byte, s_tlast=last_byte
//  output   | m_tvalid/m_tready | m_tdata=out_char, m_tlast=string_end
//  config   | cfg_we            | cfg_wdata=capacity
//
// The output register takes one character per cycle while m_tready allows; an item
// produces 0 to 11 characters, and an escape that would start at the length limit is
// dropped whole. An item that produces nothing is absorbed in its accept cycle.
// aresetn is synchronous; it clears the valid flags, phase, held byte, hex flag and count, and sets capacity to 256.
// A stalled output word holds; the next input word is taken as soon as the current
// item's last character moves into the output register or its last escape is dropped.
`default_nettype none
module c_string_literal_escaper (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [cse_pkg::CAP_W-1:0]  cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [cse_pkg::CHAR_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                       s_tuser,   // [0] has_byte
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [cse_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] out_char
    output logic                            m_tlast
);

    logic [cse_pkg::CAP_W-1:0]  capacity_reg;
    logic [cse_pkg::CHAR_W-1:0] held_byte_reg;
    logic                       held_valid_reg;
    logic                       prev_hex_reg, prev_hex_next;
    logic [cse_pkg::CAP_W-1:0]  cw_reg, cw_next;

    logic                       w_valid_reg, w_valid_next;
    cse_pkg::phase_t            phase_reg, phase_next;
    logic [cse_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [cse_pkg::CHAR_W-1:0] a_byte_reg, b_byte_reg;
    logic                       b_valid_reg, last_reg, next_digit_reg;

    logic                       in_acc, a_valid_in, b_valid_in, item_work;
    cse_pkg::phase_t            start_phase;
    logic [cse_pkg::CHAR_W-1:0] cur_byte;
    cse_pkg::esc_info_t         esc;
    cse_pkg::out_word_t         word;
    logic [cse_pkg::CAP_W-1:0]  limit;
    logic [cse_pkg::CAP_W:0]    cw_inc;
    logic                       at_limit, skip, emit, go, phase_end, item_end, out_free;
    cse_pkg::phase_t            after_phase;
    logic                       has_after;

    assign limit    = (capacity_reg == '0) ? '0 : capacity_reg - 16'd1;
    assign at_limit = cw_reg >= limit;
    assign cw_inc   = {1'b0, cw_reg} + 17'd1;
    assign cur_byte = (phase_reg == cse_pkg::PH_HELD) ? a_byte_reg : b_byte_reg;

    cse_escape u_escape (
        .byte_in       (cur_byte),
        .prev_hex      (prev_hex_reg),
        .next_is_digit (next_digit_reg && (phase_reg == cse_pkg::PH_HELD)),
        .idx           (idx_reg),
        .info          (esc)
    );

    cse_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (w_valid_reg && go && emit),
        .word_in  (word),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // What the incoming word asks for, judged against the held byte before it changes.
    always_comb begin
        a_valid_in = s_tuser && held_valid_reg;
        b_valid_in = s_tlast && (s_tuser || held_valid_reg);
        item_work  = a_valid_in || s_tlast;
        if (a_valid_in) begin
            start_phase = cse_pkg::PH_HELD;
        end else if (b_valid_in) begin
            start_phase = cse_pkg::PH_FLUSH;
        end else begin
            start_phase = cse_pkg::PH_TERM;
        end
    end

    always_comb begin
        skip        = 1'b0;
        emit        = 1'b1;
        phase_end   = 1'b1;
        has_after   = 1'b0;
        after_phase = cse_pkg::PH_TERM;
        word.ch      = esc.ch;
        word.str_end = 1'b0;
        cw_next       = cw_reg;
        prev_hex_next = prev_hex_reg;
        case (phase_reg)
            cse_pkg::PH_HELD, cse_pkg::PH_FLUSH: begin
                // An escape that would begin at the limit is dropped whole and leaves
                // the hex flag alone; one that reaches the limit is cut short.
                skip      = (idx_reg == '0) && at_limit;
                emit      = !skip;
                phase_end = skip || ((idx_reg + 3'd1) == esc.len) || (cw_inc >= {1'b0, limit});
                if (phase_reg == cse_pkg::PH_HELD) begin
                    has_after   = b_valid_reg || last_reg;
                    after_phase = b_valid_reg ? cse_pkg::PH_FLUSH : cse_pkg::PH_TERM;
                end else begin
                    has_after   = 1'b1;
                    after_phase = cse_pkg::PH_TERM;
                end
                if (emit) begin
                    cw_next = cw_inc[cse_pkg::CAP_W-1:0];
                end
                if (phase_end && !skip) begin
                    prev_hex_next = esc.is_hex;
                end
            end
            cse_pkg::PH_TERM: begin
                word.ch       = cse_pkg::CH_NUL;
                word.str_end  = 1'b1;
                cw_next       = '0;
                prev_hex_next = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        go       = skip || out_free;
        item_end = phase_end && !has_after;
    end

    assign s_tready = !w_valid_reg || (go && item_end);
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        w_valid_next = w_valid_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        if (w_valid_reg && go) begin
            if (phase_end) begin
                idx_next = '0;
                if (has_after) begin
                    phase_next = after_phase;
                end else begin
                    w_valid_next = 1'b0;
                end
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (in_acc) begin
            w_valid_next = item_work;
            phase_next   = start_phase;
            idx_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
            phase_reg   <= cse_pkg::PH_HELD;
            idx_reg     <= '0;
        end else begin
            w_valid_reg <= w_valid_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= cse_pkg::CAP_RESET;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            prev_hex_reg   <= 1'b0;
            cw_reg         <= '0;
        end else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (in_acc) begin
                if (s_tlast) begin
                    held_valid_reg <= 1'b0;
                end else if (s_tuser) begin
                    held_valid_reg <= 1'b1;
                end
                if (s_tuser) begin
                    held_byte_reg <= s_tdata;
                end
            end
            if (w_valid_reg && go) begin
                prev_hex_reg <= prev_hex_next;
                cw_reg       <= cw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            a_byte_reg     <= held_byte_reg;
            b_byte_reg     <= s_tuser ? s_tdata : held_byte_reg;
            b_valid_reg    <= b_valid_in;
            last_reg       <= s_tlast;
            next_digit_reg <= s_tdata inside {[8'h30:8'h39]};
        end
    end

`ifndef SYNTHESIS
    a_term_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == cse_pkg::CH_NUL))
        else $error("terminator word carries a nonzero character");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        w_valid_reg |-> (idx_reg < 3'd5))
        else $error("escape position out of range");

    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_valid_reg && go && (phase_reg == cse_pkg::PH_TERM))
        |=> ((cw_reg == '0) && !prev_hex_reg))
        else $error("block state not cleared after terminator");

    a_ready_needs_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && w_valid_reg) |-> (go && item_end))
        else $error("input taken while current item unfinished");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the C string literal escaper: directed table, then random blocks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_WORDS = 20;

    typedef struct {
        logic [cse_pkg::CHAR_W-1:0] data;
        bit                         has;
        bit                         last;
        bit                         typed;
        string                      text;
    } dir_row_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [cse_pkg::CAP_W-1:0]    cfg_wdata = cse_pkg::CAP_RESET;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [cse_pkg::CHAR_W-1:0]   s_tdata   = '0;
    logic                         s_tuser   = 1'b0;
    logic                         s_tlast   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [cse_pkg::CHAR_W-1:0]   m_tdata;
    logic                         m_tlast;

    // Escaper state as seen from outside, plus the characters still owed by the block.
    logic [cse_pkg::CAP_W-1:0]    cap_model = cse_pkg::CAP_RESET;
    logic [cse_pkg::CHAR_W-1:0]   held_char = '0;
    bit                           held_ok   = 1'b0;
    bit                           after_hex = 1'b0;
    logic [cse_pkg::CAP_W-1:0]    n_written = '0;
    cse_pkg::out_word_t           step_out[$];
    cse_pkg::out_word_t           lit_queue[$];

    bit no_idle = 1'b0;
    int errors = 0;
    int words_sent = 0;
    int chars_checked = 0;
    int strings_checked = 0;
    int quiet_cycles = 0;

    c_string_literal_escaper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit room_left();
        return n_written < ((cap_model == '0) ? cse_pkg::CAP_W'(0)
                                              : cap_model - cse_pkg::CAP_W'(1));
    endfunction

    function automatic void put_char(input logic [cse_pkg::CHAR_W-1:0] c);
        if (room_left()) begin
            step_out.push_back('{ch: c, str_end: 1'b0});
            n_written++;
        end
    endfunction

    function automatic bit simple_escape(input logic [cse_pkg::CHAR_W-1:0] b,
                                         output logic [cse_pkg::CHAR_W-1:0] letter);
        bit hit;
        hit = 1'b1;
        case (b)
            8'h27, 8'h22, 8'h3F, 8'h5C: letter = b;
            8'h07: letter = "a";
            8'h08: letter = "b";
            8'h0C: letter = "f";
            8'h0A: letter = "n";
            8'h0D: letter = "r";
            8'h09: letter = "t";
            8'h0B: letter = "v";
            default: begin
                letter = cse_pkg::CH_NUL;
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    function automatic logic [cse_pkg::CHAR_W-1:0] nibble_char(input logic [3:0] n);
        return (n < 4'd10) ? cse_pkg::CH_ZERO + cse_pkg::CHAR_W'(n)
                           : 8'h61 + cse_pkg::CHAR_W'(n) - 8'd10;
    endfunction

    function automatic bit is_dec(input logic [cse_pkg::CHAR_W-1:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_hexdig(input logic [cse_pkg::CHAR_W-1:0] b);
        return is_dec(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    // Spells one byte; the following byte only matters when this one is a zero.
    function automatic void escape_byte(input logic [cse_pkg::CHAR_W-1:0] b,
                                        input bit has_next,
                                        input logic [cse_pkg::CHAR_W-1:0] nxt);
        logic [cse_pkg::CHAR_W-1:0] letter;
        if (!room_left()) begin
            return;
        end
        if (b == cse_pkg::CH_NUL) begin
            put_char(cse_pkg::CH_BSLASH);
            put_char(cse_pkg::CH_ZERO);
            if (has_next && is_dec(nxt)) begin
                put_char(cse_pkg::CH_ZERO);
                put_char(cse_pkg::CH_ZERO);
            end
            after_hex = 1'b0;
        end else if (simple_escape(b, letter)) begin
            put_char(cse_pkg::CH_BSLASH);
            put_char(letter);
            after_hex = 1'b0;
        end else if (b >= 8'h20 && b <= 8'h7E && !(after_hex && is_hexdig(b))) begin
            put_char(b);
            after_hex = 1'b0;
        end else begin
            put_char(cse_pkg::CH_BSLASH);
            put_char(cse_pkg::CH_X);
            put_char(cse_pkg::CH_ZERO);
            put_char(nibble_char(b[7:4]));
            put_char(nibble_char(b[3:0]));
            after_hex = 1'b1;
        end
    endfunction

    function automatic void escape_word(input logic [cse_pkg::CHAR_W-1:0] data,
                                        input bit has, input bit last);
        step_out.delete();
        if (has) begin
            if (held_ok) begin
                escape_byte(held_char, 1'b1, data);
            end
            held_char = data;
            held_ok = 1'b1;
        end
        if (last) begin
            if (held_ok) begin
                escape_byte(held_char, 1'b0, cse_pkg::CH_NUL);
            end
            step_out.push_back('{ch: cse_pkg::CH_NUL, str_end: 1'b1});
            held_ok = 1'b0;
            after_hex = 1'b0;
            n_written = '0;
        end
    endfunction

    function automatic logic [cse_pkg::CHAR_W-1:0] pick_byte();
        logic [cse_pkg::CHAR_W-1:0] b;
        case ($urandom_range(9))
            0, 1: b = cse_pkg::CH_NUL;
            2: b = cse_pkg::CH_ZERO + cse_pkg::CHAR_W'($urandom_range(9));
            3: begin
                case ($urandom_range(10))
                    0: b = 8'h27;
                    1: b = 8'h22;
                    2: b = 8'h3F;
                    3: b = 8'h5C;
                    4: b = 8'h07;
                    5: b = 8'h08;
                    6: b = 8'h0C;
                    7: b = 8'h0A;
                    8: b = 8'h0D;
                    9: b = 8'h09;
                    default: b = 8'h0B;
                endcase
            end
            4: b = ($urandom_range(1) != 0) ? 8'h61 + cse_pkg::CHAR_W'($urandom_range(5))
                                           : 8'h41 + cse_pkg::CHAR_W'($urandom_range(5));
            5: b = ($urandom_range(1) != 0) ? cse_pkg::CHAR_W'($urandom_range(31))
                                           : cse_pkg::CHAR_W'($urandom_range(255, 127));
            default: b = cse_pkg::CHAR_W'($urandom_range(255));
        endcase
        return b;
    endfunction

    // Offers one word and records what the block owes for it once it is taken.
    task automatic send_word(input logic [cse_pkg::CHAR_W-1:0] data, input bit has,
                             input bit last, input bit typed, input string text);
        while (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        escape_word(data, has, last);
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                lit_queue.push_back('{ch: text[i], str_end: 1'b0});
            end
            if (last) begin
                lit_queue.push_back('{ch: cse_pkg::CH_NUL, str_end: 1'b1});
            end
        end else begin
            foreach (step_out[i]) begin
                lit_queue.push_back(step_out[i]);
            end
        end
        words_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (lit_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [cse_pkg::CAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_model = value;
    endtask

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 8);
    end

    always @(posedge aclk) begin
        cse_pkg::out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lit_queue.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual char %h end %0d",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = lit_queue.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.str_end) begin
                    $display("%0t: mismatch, expected char %h end %0d, actual char %h end %0d",
                             $time, want.ch, want.str_end, m_tdata, m_tlast);
                    errors++;
                end
                chars_checked++;
                if (want.str_end) begin
                    strings_checked++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL c_string_literal_escaper");
            $finish;
        end
    end

    initial begin
        dir_row_t                   dir_table[25];
        logic [cse_pkg::CAP_W-1:0]  cap_plan[12];
        int                         phase_words;
        int                         blk_len;
        bit                         closed;
        bit                         end_here;

        // Rows run at the reset capacity; typed text is what the word adds to the string, without terminator.
        dir_table = '{
            '{8'h00, 1'b1, 1'b0, 1'b1, ""},
            '{8'h35, 1'b1, 1'b0, 1'b1, "\\000"},
            '{8'h00, 1'b1, 1'b0, 1'b1, "5"},
            '{8'h00, 1'b1, 1'b1, 1'b1, "\\0\\0"},
            '{8'h27, 1'b1, 1'b0, 1'b1, ""},
            '{8'h22, 1'b1, 1'b0, 1'b1, "\\'"},
            '{8'h3F, 1'b1, 1'b0, 1'b1, "\\\""},
            '{8'h5C, 1'b1, 1'b0, 1'b1, "\\?"},
            '{8'h07, 1'b1, 1'b0, 1'b1, "\\\\"},
            '{8'h08, 1'b1, 1'b0, 1'b1, "\\a"},
            '{8'h0C, 1'b1, 1'b0, 1'b1, "\\b"},
            '{8'h0A, 1'b1, 1'b0, 1'b1, "\\f"},
            '{8'h0D, 1'b1, 1'b0, 1'b1, "\\n"},
            '{8'h09, 1'b1, 1'b0, 1'b1, "\\r"},
            '{8'h0B, 1'b1, 1'b0, 1'b1, "\\t"},
            '{8'hFF, 1'b1, 1'b0, 1'b1, "\\v"},
            '{8'h61, 1'b1, 1'b0, 1'b1, "\\x0ff"},
            '{8'h47, 1'b1, 1'b0, 1'b0, ""},
            '{8'h7F, 1'b1, 1'b0, 1'b1, "G"},
            '{8'h20, 1'b1, 1'b0, 1'b0, ""},
            '{8'h7E, 1'b1, 1'b1, 1'b1, " ~"},
            '{8'hA5, 1'b0, 1'b0, 1'b1, ""},
            '{8'h5A, 1'b0, 1'b1, 1'b1, ""},
            '{8'h39, 1'b1, 1'b0, 1'b1, ""},
            '{8'h30, 1'b1, 1'b1, 1'b1, "90"}
        };
        cap_plan = '{16'd1, 16'd65535, 16'd2, 16'd3, 16'd4, 16'd5,
                     16'd6, 16'd7, 16'd9, 16'd12, 16'd256, 16'd20};
        cap_plan[11] = cse_pkg::CAP_W'($urandom_range(40, 8));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[r]) begin
            send_word(dir_table[r].data, dir_table[r].has, dir_table[r].last,
                      dir_table[r].typed, dir_table[r].text);
        end
        wait_idle();

        foreach (cap_plan[p]) begin
            // The largest capacity and the one after it run with both sides always ready.
            no_idle = (p == 1 || p == 2);
            set_capacity(cap_plan[p]);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                blk_len = $urandom_range(10);
                closed = 1'b0;
                for (int i = 0; i < blk_len; i++) begin
                    if ($urandom_range(19) == 0) begin
                        send_word(cse_pkg::CHAR_W'($urandom_range(255)), 1'b0, 1'b0,
                                  1'b0, "");
                    end
                    end_here = (i == blk_len - 1) && ($urandom_range(9) < 7);
                    send_word(pick_byte(), 1'b1, end_here, 1'b0, "");
                    closed = end_here;
                    phase_words++;
                end
                if (!closed) begin
                    send_word(cse_pkg::CHAR_W'($urandom_range(255)), 1'b0, 1'b1, 1'b0, "");
                    phase_words++;
                end
            end
            wait_idle();
        end
        no_idle = 1'b0;

        $display("Sent %0d words: %0d directed, the rest random blocks over %0d capacities.",
                 words_sent, $size(dir_table), $size(cap_plan));
        $display("Checked %0d characters in %0d terminated strings.",
                 chars_checked, strings_checked);
        if (errors == 0 && lit_queue.size() == 0) begin
            $display("PASS c_string_literal_escaper");
        end else begin
            $display("FAIL c_string_literal_escaper");
        end
        $finish;
    end

endmodule
